### rtl/fltpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltpw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package fltpw_pkg;

  localparam int EntryBits = 64;
  localparam int IndexBits = 9;

  // command codes
  localparam logic [1:0] CMD_MAP4K = 2'd0;
  localparam logic [1:0] CMD_UNMAP = 2'd1;
  localparam logic [1:0] CMD_XLATE = 2'd2;
  localparam logic [1:0] CMD_MAP2M = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NOFRAME  = 2'd2;
  localparam logic [1:0] ST_HUGE     = 2'd3;

  // entry bits
  localparam int BitPresent = 0;
  localparam int BitHuge    = 7;
  localparam int BitGlobal  = 8;
  localparam logic [63:0] LinkFlags = 64'h7;
  localparam logic [63:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] HugeMask  = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] OffsMask  = 64'hFFF;

  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;  // latch command
  localparam logic [3:0] OP_READ    = 4'd2;  // issue entry read at level
  localparam logic [3:0] OP_CLEAR   = 4'd3;  // write zero at clear counter
  localparam logic [3:0] OP_LINK    = 4'd4;  // write link entry, take new table
  localparam logic [3:0] OP_FOLLOW  = 4'd5;  // follow read entry down
  localparam logic [3:0] OP_LEAF    = 4'd6;  // write leaf / huge entry / zero
  localparam logic [3:0] OP_RESULT  = 4'd7;  // capture result
  localparam logic [3:0] OP_ZERO    = 4'd8;  // write zero in root at clear counter

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] level;   // 0 root (47:39) .. 3 leaf (20:12)
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       present;   // read entry present
    logic       huge;      // read entry huge
    logic       global_e;  // read entry global
    logic       can_alloc; // a table frame is free
    logic       clr_last;  // clear sweep at last entry
  } stat_t;

endpackage : fltpw_pkg
`default_nettype wire

### rtl/fltpw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltpw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module fltpw_ram #(
  parameter int Width = 64,
  parameter int Depth = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : fltpw_ram
`default_nettype wire

### rtl/fltpw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltpw_datapath
// Command registers, table store, allocator, page count and result.
// ----------------------------------------------------------------------------
module fltpw_datapath
  import fltpw_pkg::*;
#(
  parameter int TableFrames = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_limit,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [47:0] in_virt,
  input  wire logic [51:0] in_phys,
  input  wire logic [11:0] in_flags,
  input  wire cmd_t        ctl,
  output      stat_t       sts,
  output      logic [1:0]  res_status,
  output      logic [51:0] res_phys,
  output      logic [31:0] res_count
);

  localparam int TBits = $clog2(TableFrames);
  localparam int ABits = TBits + IndexBits;
  localparam int CBits = $clog2(TableFrames + 1);

  logic [1:0]       cmd;
  logic [47:0]      virt;
  logic [51:0]      phys;
  logic [11:0]      flags;
  logic [TBits-1:0] cur_table;
  logic [ABits-1:0] entry_addr;
  logic [CBits-1:0] alloc_ptr;
  logic [6:0]       limit;
  logic [31:0]      page_count;
  logic [8:0]       clr_idx;
  logic [63:0]      rd;

  logic             we;
  logic [ABits-1:0] addr;
  logic [63:0]      wdata;
  logic [8:0]       vidx;
  logic [CBits-1:0] lim_eff;

  // level index select
  always_comb begin
    case (ctl.level)
      2'd0:    vidx = virt[47:39];
      2'd1:    vidx = virt[38:30];
      2'd2:    vidx = virt[29:21];
      default: vidx = virt[20:12];
    endcase
  end

  // effective table limit
  always_comb begin
    if (32'(limit) > 32'(TableFrames)) begin
      lim_eff = CBits'(TableFrames);
    end else begin
      lim_eff = CBits'(limit);
    end
  end

  // store port mux
  always_comb begin
    we    = 1'b0;
    addr  = entry_addr;
    wdata = '0;
    case (ctl.op)
      OP_READ: begin
        addr = {cur_table, vidx};
      end
      OP_CLEAR: begin
        we   = 1'b1;
        addr = {alloc_ptr[TBits-1:0], clr_idx};
      end
      OP_ZERO: begin
        we   = 1'b1;
        addr = {{TBits{1'b0}}, clr_idx};
      end
      OP_LINK: begin
        we    = 1'b1;
        wdata = (64'(alloc_ptr[TBits-1:0]) << 12) | LinkFlags;
      end
      OP_LEAF: begin
        we = 1'b1;
        case (cmd)
          CMD_MAP4K: wdata = ({12'd0, phys} & FrameMask) | 64'(flags) | 64'h1;
          CMD_MAP2M: wdata = ({12'd0, phys} & HugeMask) | 64'(flags) | 64'h81;
          default:   wdata = '0;
        endcase
      end
      default: ;
    endcase
  end

  fltpw_ram #(.Width(EntryBits), .Depth(TableFrames * 512)) u_store (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rd)
  );

  // command, walk and allocator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_ptr  <= CBits'(1);
      limit      <= 7'd64;
      page_count <= '0;
      clr_idx    <= '0;
      cur_table  <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_limit;
      end
      case (ctl.op)
        OP_LOAD: begin
          cmd       <= in_cmd;
          virt      <= in_virt;
          phys      <= in_phys;
          flags     <= in_flags;
          cur_table <= '0;
          clr_idx   <= '0;
        end
        OP_READ: entry_addr <= {cur_table, vidx};
        OP_CLEAR, OP_ZERO: clr_idx <= clr_idx + 9'd1;
        OP_LINK: begin
          cur_table <= alloc_ptr[TBits-1:0];
          alloc_ptr <= alloc_ptr + CBits'(1);
          clr_idx   <= '0;
        end
        OP_FOLLOW: cur_table <= rd[12 +: TBits];
        OP_LEAF: begin
          if (cmd == CMD_MAP4K && !rd[BitPresent] && !flags[BitGlobal]
              && page_count != 32'hFFFF_FFFF) begin
            page_count <= page_count + 32'd1;
          end else if (cmd == CMD_UNMAP && !rd[BitGlobal] && page_count != 32'd0) begin
            page_count <= page_count - 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.op == OP_RESULT) begin
      res_status <= ctl.status;
      res_phys   <= (cmd == CMD_XLATE && ctl.status == ST_OK) ?
                    ((rd[51:0] & FrameMask[51:0]) | {40'd0, virt[11:0]}) : 52'd0;
      res_count  <= page_count;
    end
  end

  assign sts.cmd       = cmd;
  assign sts.present   = rd[BitPresent];
  assign sts.huge      = rd[BitHuge];
  assign sts.global_e  = rd[BitGlobal];
  assign sts.can_alloc = alloc_ptr < lim_eff;
  assign sts.clr_last  = clr_idx == 9'd511;

`ifndef ASSERT_OFF
  // allocator never passes the frame count
  assert property (@(posedge clk) disable iff (rst) alloc_ptr <= CBits'(TableFrames))
    else $error("allocator overran table frames");
  // a link is only taken while a frame is free
  assert property (@(posedge clk) disable iff (rst) ctl.op == OP_LINK |-> sts.can_alloc)
    else $error("link without free frame");
  // allocator advances by one on a link
  assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_LINK |=> alloc_ptr == $past(alloc_ptr) + CBits'(1))
    else $error("allocator step wrong");
`endif

endmodule : fltpw_datapath
`default_nettype wire

### rtl/fltpw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltpw_ctrl
// Walk sequencer: reads, table allocation with clear, leaf update, result.
// ----------------------------------------------------------------------------
module fltpw_ctrl
  import fltpw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output      logic  in_ready,
  output      logic  out_valid,
  input  wire logic  out_ready,
  input  wire stat_t sts,
  output      cmd_t  ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_WAIT   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_CLEAR  = 4'd4;
  localparam logic [3:0] S_LINK   = 4'd5;
  localparam logic [3:0] S_LEAF   = 4'd6;
  localparam logic [3:0] S_RES    = 4'd7;
  localparam logic [3:0] S_RESW   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_HOLD   = 4'd10;
  localparam logic [3:0] S_INIT   = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] level, level_next;
  logic [1:0] status, status_next;
  logic       wrote_link, wrote_link_next;

  assign in_ready = state == S_IDLE;

  // sequencer
  always_comb begin
    state_next      = state;
    level_next      = level;
    status_next     = status;
    wrote_link_next = wrote_link;
    ctl             = '{op: OP_NONE, level: level, status: status};
    case (state)
      S_INIT: begin
        // root table sweep after reset
        ctl.op = OP_ZERO;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.op      = OP_LOAD;
          level_next  = 2'd0;
          status_next = ST_OK;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        ctl.op          = OP_READ;
        wrote_link_next = 1'b0;
        state_next      = S_WAIT;
      end
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        if (level == 2'd3 || (sts.cmd == CMD_MAP2M && level == 2'd2)) begin
          // leaf slot reached
          if (sts.cmd == CMD_MAP4K || sts.cmd == CMD_MAP2M) begin
            state_next = S_LEAF;
          end else if (!sts.present) begin
            status_next = ST_UNMAPPED;
            state_next  = S_RES;
          end else if (sts.cmd == CMD_UNMAP) begin
            state_next = S_LEAF;
          end else begin
            state_next = S_RES;
          end
        end else if (!sts.present) begin
          if (sts.cmd == CMD_UNMAP || sts.cmd == CMD_XLATE) begin
            status_next = ST_UNMAPPED;
            state_next  = S_RES;
          end else if (!sts.can_alloc) begin
            status_next = ST_NOFRAME;
            state_next  = S_RES;
          end else begin
            state_next = S_CLEAR;
          end
        end else if (!wrote_link && sts.huge && level != 2'd0
                     && sts.cmd != CMD_MAP2M) begin
          status_next = ST_HUGE;
          state_next  = S_RES;
        end else begin
          ctl.op     = OP_FOLLOW;
          level_next = level + 2'd1;
          state_next = S_READ;
        end
      end
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        // link written; new table is all zero so the next level is absent
        ctl.op          = OP_LINK;
        level_next      = level + 2'd1;
        state_next      = S_READ;
      end
      S_LEAF: begin
        ctl.op     = OP_LEAF;
        state_next = S_RES;
      end
      S_RES: begin
        ctl.op     = OP_READ;
        state_next = S_RESW;
      end
      S_RESW: state_next = S_OUT;
      S_OUT: begin
        ctl.op     = OP_RESULT;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = state == S_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      level      <= 2'd0;
      status     <= ST_OK;
      wrote_link <= 1'b0;
    end else begin
      state      <= state_next;
      level      <= level_next;
      status     <= status_next;
      wrote_link <= wrote_link_next;
    end
  end

`ifndef ASSERT_OFF
  // input taken only when idle
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> state == S_READ)
    else $error("accept did not start walk");
  // result held until taken
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  // never both sides at once
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
`endif

endmodule : fltpw_ctrl
`default_nettype wire

### rtl/four_level_page_table_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level radix page table kept in an on-chip table store.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_ready carry one command (cmd, virt_addr, phys_addr,
//   page_flags); out_valid/out_ready return one result per command
//   (status, phys_out, mapped_count) from a result register.
//   cfg_valid/cfg_ready write table_limit; cfg_ready is always high.
//   One command is worked at a time. Each level read goes through the
//   single-port table store (registered read); the next command is taken
//   in the cycle after the result is taken. Each new table adds a clear
//   sweep of its 512 entries and a link write. in_ready is low from
//   acceptance until the result is taken; a stalled receiver holds the
//   result and the block.
//   Synchronous reset sets the allocator to one table, the page count to
//   zero and table_limit to 64, then a sweep clears all 512 entries of the
//   root table; in_ready stays low during the sweep.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
  import fltpw_pkg::*;
#(
  parameter int TABLE_FRAMES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [6:0]  table_limit,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [47:0] virt_addr,
  input  wire logic [51:0] phys_addr,
  input  wire logic [11:0] page_flags,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  status,
  output      logic [51:0] phys_out,
  output      logic [31:0] mapped_count
);

  cmd_t  ctl;
  stat_t sts;

  assign cfg_ready = 1'b1;

  fltpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  fltpw_datapath #(.TableFrames(TABLE_FRAMES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_limit (table_limit),
    .in_cmd    (cmd),
    .in_virt   (virt_addr),
    .in_phys   (phys_addr),
    .in_flags  (page_flags),
    .ctl       (ctl),
    .sts       (sts),
    .res_status(status),
    .res_phys  (phys_out),
    .res_count (mapped_count)
  );

endmodule : four_level_page_table_walker
`default_nettype wire
